// ----- src/gmr_pkg.sv -----
// ----------------------------------------------------------------------------
// gmr_pkg: shared types and constants for the grid movement range block
// item and result transaction structs, cell control and state codes
// ----------------------------------------------------------------------------
package gmr_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;
  localparam logic [4:0] DIST_SAT = 5'd31;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic       func;
    logic [4:0] row;
    logic [4:0] col;
    logic [3:0] cost;
    logic [3:0] budget;
  } item_t;

  typedef struct packed {
    logic [4:0]  out_row;
    logic [31:0] reach_mask;
    logic [31:0] limit_mask;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_RELAX,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_STEP,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [6:0] start_row;
    logic [6:0] start_col;
    logic [6:0] nr;
    logic [6:0] nc;
    logic       load_en;
    logic [6:0] load_row;
    logic [6:0] load_col;
    logic [3:0] load_cost;
  } cell_ctl_t;

endpackage

// ----- src/gmr_row_cell.sv -----
// ----------------------------------------------------------------------------
// gmr_row_cell: one grid row of the relaxation chain
// holds the row's entry costs and distances, relaxes from its neighbors
// ----------------------------------------------------------------------------
module gmr_row_cell
  import gmr_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int ROW_ID   = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [MAX_COLS-1:0][4:0] up_dist,
  input  logic [MAX_COLS-1:0][4:0] dn_dist,
  output logic [MAX_COLS-1:0][4:0] row_dist,
  output logic                     changed
);

  localparam logic [6:0] ROW_ID7 = 7'(ROW_ID);

  logic [MAX_COLS-1:0][3:0] cost;
  logic [MAX_COLS-1:0][4:0] row_dist_next;
  logic [MAX_COLS-1:0]      chg;
  logic                     row_active;

  assign row_active = ROW_ID7 < ctl.nr;

  always_ff @(posedge clk) begin
    for (int c = 0; c < MAX_COLS; c++) begin
      if (ctl.load_en && ctl.load_row == ROW_ID7 && ctl.load_col == 7'(c)) begin
        cost[c] <= ctl.load_cost;
      end
    end
  end

  always_comb begin
    logic [4:0] m;
    logic [5:0] sum;
    row_dist_next = row_dist;
    chg = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      m = DIST_SAT;
      sum = 6'd0;
      case (ctl.op)
        OP_CLEAR: begin
          row_dist_next[c] = DIST_SAT;
          if (row_active && ctl.start_row == ROW_ID7 && ctl.start_col == 7'(c) &&
              ctl.start_col < ctl.nc) begin
            row_dist_next[c] = 5'd0;
          end
        end
        OP_STEP: begin
          if (row_active && 7'(c) < ctl.nc) begin
            if (up_dist[c] < m) m = up_dist[c];
            if (dn_dist[c] < m) m = dn_dist[c];
            if (c > 0 && row_dist[(c > 0) ? c - 1 : 0] < m) begin
              m = row_dist[(c > 0) ? c - 1 : 0];
            end
            if (c < MAX_COLS - 1 && row_dist[(c < MAX_COLS - 1) ? c + 1 : c] < m) begin
              m = row_dist[(c < MAX_COLS - 1) ? c + 1 : c];
            end
            // saturating add of the entry cost
            if (m != DIST_SAT) begin
              sum = {1'b0, m} + {2'b00, cost[c]};
              if (sum > {1'b0, DIST_SAT}) sum = {1'b0, DIST_SAT};
              if (sum[4:0] < row_dist[c]) begin
                row_dist_next[c] = sum[4:0];
                chg[c] = 1'b1;
              end
            end
          end
        end
        OP_SHIFT: row_dist_next[c] = dn_dist[c];
        default: row_dist_next[c] = row_dist[c];
      endcase
    end
  end

  assign changed = |chg;

  always_ff @(posedge clk) begin
    row_dist <= row_dist_next;
  end

endmodule

// ----- src/grid_movement_range.sv -----
// ----------------------------------------------------------------------------
// grid_movement_range: movement range on a 4-neighbour cost grid
// chain of row cells relaxing least-cost distances, one result per row
// ----------------------------------------------------------------------------
// A load transaction (func 0) writes one cell's entry cost and gives no
// result. A query transaction (func 1) raises busy, clears the distances,
// then relaxes every cell of the grid in parallel once per cycle until a
// pass changes nothing, and finally emits one result per row in use, one
// per cycle, with last on the final row. A query therefore keeps busy high
// through the clear, the relax passes and the emission of every row in
// use. Each result is shown for exactly one cycle with result_valid; the
// receiver cannot stall it. start is taken only while busy is low.
// Configuration writes are always ready.
module grid_movement_range
  import gmr_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  output result_t    result,
  output logic       result_valid
);

  localparam int ROWS_HI = (MAX_ROWS < 32) ? MAX_ROWS : 32;

  state_t     state, state_next;
  logic [5:0] rows_in_use, cols_in_use;
  logic [6:0] nr, nc;
  logic [6:0] start_row, start_col;
  logic [3:0] budget;
  logic [4:0] cnt;
  cell_ctl_t  ctl;

  logic [MAX_ROWS:0][MAX_COLS-1:0][4:0] chain;   // chain[i] is row i's distances
  logic [MAX_COLS-1:0][4:0]             sat_row;
  logic [MAX_ROWS-1:0]                  row_chg;
  logic                                 any_chg;

  // configuration registers, written any time
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 6'd32;
      cols_in_use <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped grid size
  always_comb begin
    nr = {1'b0, rows_in_use};
    if (nr < 7'd1) nr = 7'd1;
    if (nr > 7'(ROWS_HI)) nr = 7'(ROWS_HI);
    nc = {1'b0, cols_in_use};
    if (nc < 7'd1) nc = 7'd1;
    if (nc > 7'(MAX_COLS)) nc = 7'(MAX_COLS);
  end

  // query transaction registers
  always_ff @(posedge clk) begin
    if (start && !busy && item.func == FUNC_QUERY) begin
      start_row <= {2'b00, item.row};
      start_col <= {2'b00, item.col};
      budget    <= item.budget;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start && item.func == FUNC_QUERY) state_next = ST_INIT;
      ST_INIT:  state_next = ST_RELAX;
      ST_RELAX: if (!any_chg) state_next = ST_EMIT;
      ST_EMIT:  if ({2'b00, cnt} + 7'd1 == nr) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT) cnt <= cnt + 5'd1;
      else cnt <= '0;
    end
  end

  // cell control
  always_comb begin
    ctl.op        = OP_NOP;
    ctl.start_row = start_row;
    ctl.start_col = start_col;
    ctl.nr        = nr;
    ctl.nc        = nc;
    ctl.load_en   = start && !busy && item.func == FUNC_LOAD;
    ctl.load_row  = {2'b00, item.row};
    ctl.load_col  = {2'b00, item.col};
    ctl.load_cost = item.cost;
    case (state)
      ST_INIT:  ctl.op = OP_CLEAR;
      ST_RELAX: ctl.op = OP_STEP;
      ST_EMIT:  ctl.op = OP_SHIFT;
      default:  ctl.op = OP_NOP;
    endcase
  end

  assign busy = state != ST_IDLE;

  // row cells; edge rows see saturated neighbors
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) sat_row[c] = DIST_SAT;
  end
  assign chain[MAX_ROWS] = sat_row;

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    gmr_row_cell #(
      .MAX_COLS (MAX_COLS),
      .ROW_ID   (r)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .up_dist  ((r == 0) ? sat_row : chain[(r == 0) ? 0 : r - 1]),
      .dn_dist  (chain[r + 1]),
      .row_dist (chain[r]),
      .changed  (row_chg[r])
    );
  end

  assign any_chg = |row_chg;

  // result from the head of the chain, rows shift up once per cycle
  always_comb begin
    result.out_row    = cnt;
    result.last       = ({2'b00, cnt} + 7'd1 == nr);
    result.reach_mask = '0;
    result.limit_mask = '0;
    for (int c = 0; c < 32; c++) begin
      if (c < MAX_COLS && 7'(c) < nc &&
          !({2'b00, cnt} == start_row && 7'(c) == start_col)) begin
        result.reach_mask[c] = chain[0][(c < MAX_COLS) ? c : 0] <= {1'b0, budget};
        result.limit_mask[c] = chain[0][(c < MAX_COLS) ? c : 0] == {1'b0, budget};
      end
    end
  end

  assign result_valid = state == ST_EMIT;

`ifndef SYNTHESIS
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside a query");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !busy) else $error("busy after last row");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.func == FUNC_QUERY |=> busy && !result_valid)
    else $error("query not started");
`endif

endmodule
